### src/ldkb_pkg.sv
package ldkb_pkg;

   localparam int unsigned SampleWidth = 10;
   localparam int unsigned LevelWidth  = 7;
   localparam int unsigned PwmWidth    = 8;
   localparam int unsigned CsrIdxWidth = 2;

   localparam logic [LevelWidth-1:0] LevelMax          = 7'd100;
   localparam logic [LevelWidth-1:0] CounterLevelReset = 7'd50;
   localparam logic [LevelWidth-1:0] RingLevelReset    = 7'd100;
   localparam logic [LevelWidth-1:0] StepReset         = 7'd10;
   localparam logic [LevelWidth-1:0] ToleranceReset    = 7'd50;
   localparam logic [LevelWidth-1:0] CornerReset       = 7'd100;

   // floor(x * 255 / 100) as x * (255 * 5243) >> 19, exact for x up to 100.
   localparam logic [20:0] PwmScale = 21'd1336965;

   typedef enum logic [2:0] {
      BTN_NONE   = 3'd0,
      BTN_UP     = 3'd1,
      BTN_MIDDLE = 3'd2,
      BTN_DOWN   = 3'd3,
      BTN_RIGHT  = 3'd4,
      BTN_LEFT   = 3'd5
   } button_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_LEVEL_STEP      = 2'd0,
      CSR_MATCH_TOLERANCE = 2'd1,
      CSR_CORNER_LEVEL    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [LevelWidth-1:0] level_step;
      logic [LevelWidth-1:0] match_tolerance;
      logic [LevelWidth-1:0] corner_level;
   } cfg_type;

   typedef struct packed {
      logic       valid;
      button_type button;
   } btn_word_type;

   // Ideal inverted reading of each ladder level, n * 1024 / 5.
   function automatic logic [10:0] ladder_ideal(input logic [2:0] n);
      logic [10:0] ideal;
      case (n)
         3'd1:    ideal = 11'd204;
         3'd2:    ideal = 11'd409;
         3'd3:    ideal = 11'd614;
         3'd4:    ideal = 11'd819;
         3'd5:    ideal = 11'd1024;
         default: ideal = 11'd0;
      endcase
      return ideal;
   endfunction

   // Level percentage to PWM compare value; levels above 100 count as 100.
   function automatic logic [PwmWidth-1:0] level_to_pwm(input logic [LevelWidth-1:0] lvl);
      logic [LevelWidth-1:0] clamped;
      logic [27:0]           prod;
      clamped = (lvl > LevelMax) ? LevelMax : lvl;
      prod    = 28'(clamped) * 28'(PwmScale);
      return prod[26:19];
   endfunction

endpackage

### src/ldkb_decode.sv
module ldkb_decode
   import ldkb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_stall,
   input  logic [SampleWidth-1:0] in_sample,
   input  logic [LevelWidth-1:0]  match_tolerance,
   output btn_word_type           out_word,
   input  logic                   out_ready
);

   logic                   s1_valid_ff, s1_valid_in;
   logic [SampleWidth-1:0] sample_ff;
   logic                   s2_valid_ff, s2_valid_in;
   button_type             button_ff, button_in;
   logic                   s1_ready, s2_ready;

   logic [10:0] inv;
   logic [12:0] scaled;
   logic [2:0]  nearest;
   logic [10:0] ideal;
   logic [10:0] distance;

   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_stall = !s1_ready;

   assign s1_valid_in = s1_ready ? in_valid : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;

   // Invert the reading and round to the nearest fifth of full scale.
   always_comb begin
      inv      = 11'd1024 - {1'b0, sample_ff};
      scaled   = {inv, 2'b00} + {2'b00, inv} + 13'd512;
      nearest  = scaled[12:10];
      ideal    = ladder_ideal(nearest);
      distance = (ideal > inv) ? (ideal - inv) : (inv - ideal);
      if (nearest != 3'd0 && distance < {4'b0000, match_tolerance}) begin
         button_in = button_type'(nearest);
      end else begin
         button_in = BTN_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && s1_ready) begin
         sample_ff <= in_sample;
      end
      if (s1_valid_ff && s2_ready) begin
         button_ff <= button_in;
      end
   end

   assign out_word.valid  = s2_valid_ff;
   assign out_word.button = button_ff;

endmodule

### src/ldkb_ctrl.sv
module ldkb_ctrl
   import ldkb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  btn_word_type        in_word,
   output logic                in_ready,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [PwmWidth-1:0] rsp_counter_pwm,
   output logic [PwmWidth-1:0] rsp_ring_pwm,
   output logic [PwmWidth-1:0] rsp_corner_pwm,
   output logic                rsp_mode_led,
   output logic [2:0]          rsp_pressed_button
);

   button_type            prev_button_ff, prev_button_in;
   logic [LevelWidth-1:0] counter_level_ff, counter_level_in;
   logic [LevelWidth-1:0] ring_level_ff, ring_level_in;
   logic                  standby_ff, standby_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PwmWidth-1:0]   counter_pwm_ff, ring_pwm_ff, corner_pwm_ff;
   logic                  mode_led_ff;
   logic [2:0]            pressed_ff;
   logic                  take;

   function automatic logic [LevelWidth-1:0] step_up(input logic [LevelWidth-1:0] lvl,
                                                      input logic [LevelWidth-1:0] step);
      logic [LevelWidth:0] sum;
      sum = {1'b0, lvl} + {1'b0, step};
      return (sum > {1'b0, LevelMax}) ? LevelMax : sum[LevelWidth-1:0];
   endfunction

   function automatic logic [LevelWidth-1:0] step_down(input logic [LevelWidth-1:0] lvl,
                                                        input logic [LevelWidth-1:0] step);
      return (lvl < step) ? '0 : (lvl - step);
   endfunction

   assign in_ready     = !rsp_valid_ff || !rsp_stall;
   assign take         = in_word.valid && in_ready;
   assign rsp_valid_in = in_ready ? in_word.valid : rsp_valid_ff;

   always_comb begin
      prev_button_in   = prev_button_ff;
      counter_level_in = counter_level_ff;
      ring_level_in    = ring_level_ff;
      standby_in       = standby_ff;
      if (take && in_word.button != prev_button_ff) begin
         prev_button_in = in_word.button;
         case (in_word.button)
            BTN_UP:     counter_level_in = step_up(counter_level_ff, cfg.level_step);
            BTN_MIDDLE: standby_in       = !standby_ff;
            BTN_DOWN:   counter_level_in = step_down(counter_level_ff, cfg.level_step);
            BTN_RIGHT:  ring_level_in    = step_up(ring_level_ff, cfg.level_step);
            BTN_LEFT:   ring_level_in    = step_down(ring_level_ff, cfg.level_step);
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_button_ff   <= BTN_NONE;
         counter_level_ff <= CounterLevelReset;
         ring_level_ff    <= RingLevelReset;
         standby_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         prev_button_ff   <= prev_button_in;
         counter_level_ff <= counter_level_in;
         ring_level_ff    <= ring_level_in;
         standby_ff       <= standby_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         counter_pwm_ff <= standby_in ? '0 : level_to_pwm(counter_level_in);
         ring_pwm_ff    <= standby_in ? '0 : level_to_pwm(ring_level_in);
         corner_pwm_ff  <= standby_in ? '0 : level_to_pwm(cfg.corner_level);
         mode_led_ff    <= standby_in;
         pressed_ff     <= in_word.button;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_counter_pwm    = counter_pwm_ff;
   assign rsp_ring_pwm       = ring_pwm_ff;
   assign rsp_corner_pwm     = corner_pwm_ff;
   assign rsp_mode_led       = mode_led_ff;
   assign rsp_pressed_button = pressed_ff;

`ifndef ASSERT_OFF
   a_levels_in_range: assert property (@(posedge clock) disable iff (reset)
      counter_level_ff <= LevelMax && ring_level_ff <= LevelMax)
      else $error("brightness level left its range");

   a_standby_by_middle: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$stable(standby_ff) |->
         $past(take) && $past(in_word.button) == BTN_MIDDLE)
      else $error("standby changed without a middle press");

   a_pending_mode_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> mode_led_ff == standby_ff)
      else $error("pending word mode differs from standby state");

   a_pending_counter_pwm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !mode_led_ff |-> counter_pwm_ff == level_to_pwm(counter_level_ff))
      else $error("pending counter PWM differs from counter level");
`endif

endmodule

### src/ladder_keypad_brightness_control.sv
// Ladder keypad brightness control.
//
// The request channel (req_valid, req_stall, req_adc_sample) takes one raw
// ladder keypad reading per word. The response channel (rsp_valid, rsp_stall
// and the rsp_ payload ports) returns exactly one word for each request: the
// three PWM compare values, the mode LED and the decoded button.
// A word is moved at a rising edge where valid is high and stall is low.
// The register port (csr_valid, csr_ready, csr_index, csr_data) writes the
// step, tolerance and corner level; it is always ready, and writes to an
// unknown index are dropped. Registers should only be written while idle.
// From request acceptance to the response word, a reading passes an input
// register, the decoded button register and the response register. One
// word is accepted every cycle unless the receiver stalls; the rate is set by
// the single state update in the response stage, which handles one button
// per cycle. When the receiver stalls, the response holds and the three
// stages fill up before req_stall rises, so the sender is stalled only once
// all are full. Synchronous reset empties the pipeline, sets the levels to
// 50 and 100, leaves standby and restores the register defaults.
module ladder_keypad_brightness_control
   import ldkb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SampleWidth-1:0] req_adc_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [PwmWidth-1:0]    rsp_counter_pwm,
   output logic [PwmWidth-1:0]    rsp_ring_pwm,
   output logic [PwmWidth-1:0]    rsp_corner_pwm,
   output logic                   rsp_mode_led,
   output logic [2:0]             rsp_pressed_button,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [LevelWidth-1:0]  csr_data
);

   cfg_type      cfg_ff;
   btn_word_type btn_word;
   logic         ctrl_ready;

   // The register port never pushes back.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.level_step      <= StepReset;
         cfg_ff.match_tolerance <= ToleranceReset;
         cfg_ff.corner_level    <= CornerReset;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LEVEL_STEP:      cfg_ff.level_step      <= csr_data;
            CSR_MATCH_TOLERANCE: cfg_ff.match_tolerance <= csr_data;
            CSR_CORNER_LEVEL:    cfg_ff.corner_level    <= csr_data;
            default:             ;
         endcase
      end
   end

   // Sample register and ladder decode, ending in the button register.
   ldkb_decode u_decode (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (req_valid),
      .in_stall        (req_stall),
      .in_sample       (req_adc_sample),
      .match_tolerance (cfg_ff.match_tolerance),
      .out_word        (btn_word),
      .out_ready       (ctrl_ready)
   );

   // Edge detection on the button, level and standby state, response register.
   ldkb_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .in_word            (btn_word),
      .in_ready           (ctrl_ready),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_counter_pwm    (rsp_counter_pwm),
      .rsp_ring_pwm       (rsp_ring_pwm),
      .rsp_corner_pwm     (rsp_corner_pwm),
      .rsp_mode_led       (rsp_mode_led),
      .rsp_pressed_button (rsp_pressed_button)
   );

endmodule

### test/tb_top.sv
import ldkb_pkg::*;

// One response word as the brightness controller should return it.
typedef struct {
   logic [PwmWidth-1:0] counter_pwm;
   logic [PwmWidth-1:0] ring_pwm;
   logic [PwmWidth-1:0] corner_pwm;
   logic                mode_led;
   button_type          button;
} lamp_word_type;

class brightness_scoreboard;
   int unsigned step_size;
   int unsigned tolerance;
   int unsigned corner_percent;

   button_type  last_button;
   int unsigned counter_percent;
   int unsigned ring_percent;
   bit          standby;

   lamp_word_type due_words[$];
   int unsigned   errors;
   int unsigned   words_seen;

   function new();
      step_size       = StepReset;
      tolerance       = ToleranceReset;
      corner_percent  = CornerReset;
      last_button     = BTN_NONE;
      counter_percent = CounterLevelReset;
      ring_percent    = RingLevelReset;
      standby         = 1'b0;
      errors          = 0;
      words_seen      = 0;
   endfunction

   task report(string what);
      errors++;
      if (errors <= 40) begin
         $display("%0t: %s", $time, what);
      end
   endtask

   function void write_register(logic [CsrIdxWidth-1:0] idx, logic [LevelWidth-1:0] data);
      case (idx)
         CSR_LEVEL_STEP:      step_size      = data;
         CSR_MATCH_TOLERANCE: tolerance      = data;
         CSR_CORNER_LEVEL:    corner_percent = data;
         default: ;
      endcase
   endfunction

   function button_type decode_button(logic [SampleWidth-1:0] adc);
      int unsigned v;
      int unsigned n;
      int unsigned ideal;
      int unsigned distance;
      v = 1024 - adc;
      n = (v * 5 + 512) / 1024;
      if (n == 0) return BTN_NONE;
      ideal    = n * 1024 / 5;
      distance = (ideal > v) ? ideal - v : v - ideal;
      if (distance < tolerance) return button_type'(n[2:0]);
      return BTN_NONE;
   endfunction

   function int unsigned raised(int unsigned lvl);
      return (lvl + step_size > LevelMax) ? LevelMax : lvl + step_size;
   endfunction

   function int unsigned lowered(int unsigned lvl);
      return (lvl < step_size) ? 0 : lvl - step_size;
   endfunction

   function logic [PwmWidth-1:0] percent_to_pwm(int unsigned lvl);
      if (lvl > LevelMax) lvl = LevelMax;
      return PwmWidth'(lvl * 255 / 100);
   endfunction

   // Advances the keypad state for one accepted reading and queues its word.
   function void note_sample(logic [SampleWidth-1:0] adc);
      lamp_word_type w;
      button_type    b;
      b = decode_button(adc);
      if (b != last_button) begin
         case (b)
            BTN_UP:     counter_percent = raised(counter_percent);
            BTN_MIDDLE: standby         = !standby;
            BTN_DOWN:   counter_percent = lowered(counter_percent);
            BTN_RIGHT:  ring_percent    = raised(ring_percent);
            BTN_LEFT:   ring_percent    = lowered(ring_percent);
            default: ;
         endcase
         last_button = b;
      end
      w.button = b;
      if (standby) begin
         w.counter_pwm = '0;
         w.ring_pwm    = '0;
         w.corner_pwm  = '0;
         w.mode_led    = 1'b1;
      end else begin
         w.counter_pwm = percent_to_pwm(counter_percent);
         w.ring_pwm    = percent_to_pwm(ring_percent);
         w.corner_pwm  = percent_to_pwm(corner_percent);
         w.mode_led    = 1'b0;
      end
      due_words.push_back(w);
   endfunction

   task compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) begin
         report($sformatf("word %0d %s: got %0d, expected %0d", words_seen, name, got, want));
      end
   endtask

   task check_word(logic [PwmWidth-1:0] counter, logic [PwmWidth-1:0] ring,
                   logic [PwmWidth-1:0] corner, logic led, logic [2:0] button);
      lamp_word_type w;
      words_seen++;
      if (due_words.size() == 0) begin
         report($sformatf("word %0d arrived with nothing outstanding", words_seen));
         return;
      end
      w = due_words.pop_front();
      compare_field("counter_pwm", counter, w.counter_pwm);
      compare_field("ring_pwm", ring, w.ring_pwm);
      compare_field("corner_pwm", corner, w.corner_pwm);
      compare_field("mode_led", led, w.mode_led);
      compare_field("pressed_button", button, w.button);
   endtask
endclass

module tb_top;

   // Index two bits wide has one spare code; writes to it must be dropped.
   localparam logic [CsrIdxWidth-1:0] CsrIndexUnused = 2'd3;
   // Cycles allowed for the pipeline to settle after draining.
   localparam int unsigned SettleCycles = 4;

   logic                   clock;
   logic                   reset          = 1'b1;
   logic                   req_valid      = 1'b0;
   logic                   req_stall;
   logic [SampleWidth-1:0] req_adc_sample = '0;
   logic                   rsp_valid;
   logic                   rsp_stall      = 1'b0;
   logic [PwmWidth-1:0]    rsp_counter_pwm;
   logic [PwmWidth-1:0]    rsp_ring_pwm;
   logic [PwmWidth-1:0]    rsp_corner_pwm;
   logic                   rsp_mode_led;
   logic [2:0]             rsp_pressed_button;
   logic                   csr_valid      = 1'b0;
   logic                   csr_ready;
   logic [CsrIdxWidth-1:0] csr_index      = '0;
   logic [LevelWidth-1:0]  csr_data       = '0;

   brightness_scoreboard sb;
   int unsigned          burst_left;

   // Opening sequence at the reset settings (step 10, tolerance 50, corner 100).
   // Readings are written as raw samples: a button n sits at 1024 - n*1024/5.
   int unsigned key_script [0:19] = '{
      1023,  // released, largest reading
      820,   // up: counter 50 to 60
      820,   // up held: no further change
      1023,  // release
      820,   // up again: 70
      1023,
      410,   // down straight from release: 60
      205,   // right: ring already at 100, so it clamps
      0,     // left, smallest reading: ring 90
      615,   // middle: into standby, all PWM values drop to zero
      820,   // up while in standby: level moves, outputs stay zero
      1023,
      615,   // middle: out of standby, the new counter level shows
      771,   // one below the tolerance from the up level: still up
      1023,
      770,   // exactly the tolerance away: no button
      512,   // mid-scale reading between two levels
      1,
      922,   // highest inverted value that still rounds to no level
      921    // rounds to up but lies far outside the tolerance
   };

   ladder_keypad_brightness_control dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_adc_sample     (req_adc_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_counter_pwm    (rsp_counter_pwm),
      .rsp_ring_pwm       (rsp_ring_pwm),
      .rsp_corner_pwm     (rsp_corner_pwm),
      .rsp_mode_led       (rsp_mode_led),
      .rsp_pressed_button (rsp_pressed_button),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Offers one reading and holds it until the block takes it. The sender works
   // in bursts; when a burst runs out, valid may drop for a random gap first. Valid
   // stays high from one word to the next inside a burst, so it is never
   // lowered and raised at the same edge.
   task automatic send_sample(input int unsigned adc);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_adc_sample <= SampleWidth'(adc);
      do @(posedge clock); while (req_stall);
      sb.note_sample(SampleWidth'(adc));
   endtask

   // Waits until every outstanding word has come back, then lets the pipeline
   // settle.
   task automatic wait_drained();
      while (sb.due_words.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Holds the register write until the block takes it. Valid is left high so
   // that back-to-back writes need no second assignment in one step.
   task automatic write_register(input logic [CsrIdxWidth-1:0] idx, input int unsigned data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= LevelWidth'(data);
      do @(posedge clock); while (!csr_ready);
      sb.write_register(idx, LevelWidth'(data));
   endtask

   // Registers change only with the block idle: the sender stops, everything
   // in flight is collected, and only then are the writes made. The spare index
   // is written last, so a write that leaked into a register would show.
   task automatic set_registers(input int unsigned step, input int unsigned tol,
                                input int unsigned corner);
      req_valid  <= 1'b0;
      burst_left = 0;
      wait_drained();
      write_register(CSR_LEVEL_STEP, step);
      write_register(CSR_MATCH_TOLERANCE, tol);
      write_register(CSR_CORNER_LEVEL, corner);
      write_register(CsrIndexUnused, $urandom_range(0, 127));
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Random keypad traffic. Most of it is press and release sequences: a button
   // held for a few polls with the reading scattered a little beyond the
   // tolerance either side of its level, usually followed by a release. Some
   // presses go straight to another button with no release between. In about a
   // fifth of the rounds, a single noise reading over the whole range is sent.
   task automatic run_phase(input int unsigned count);
      int unsigned sent;
      int unsigned n;
      int unsigned hold;
      int          span;
      int          v;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 99) < 20) begin
            send_sample($urandom_range(0, 1023));
            sent++;
         end else begin
            n    = $urandom_range(1, 5);
            hold = $urandom_range(1, 4);
            span = int'(sb.tolerance) + 3;
            repeat (hold) begin
               v = int'(n * 1024 / 5) + int'($urandom_range(0, 2 * span)) - span;
               if (v < 1) v = 1;
               if (v > 1024) v = 1024;
               send_sample(1024 - v);
               sent++;
            end
            if ($urandom_range(0, 99) < 80) begin
               send_sample($urandom_range(922, 1023));
               sent++;
            end
         end
      end
   endtask

   // Stimulus: the opening sequence, then eight random phases, each at its own
   // register setting. The extremes come first: a step of one with a tolerance
   // of one, the widest legal values, then a zero step with zero tolerance and
   // a corner level above one hundred, then all-ones registers.
   initial begin
      sb = new();
      burst_left = 30;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      foreach (key_script[i]) send_sample(key_script[i]);
      run_phase(190);
      for (int phase = 1; phase <= 7; phase++) begin
         case (phase)
            1:       set_registers(1, 1, 0);
            2:       set_registers(100, 102, 100);
            3:       set_registers(0, 0, 127);
            4:       set_registers(127, 127, 127);
            default: set_registers($urandom_range(0, 127), $urandom_range(0, 127),
                                   $urandom_range(0, 127));
         endcase
         run_phase(190);
      end
      req_valid <= 1'b0;
      wait_drained();
      if (sb.errors == 0 && sb.due_words.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

   // The receiver opens with a long hold-off while the sender keeps offering
   // the opening sequence, so the pipeline fills and the input stalls. After
   // that it moves between free-flowing stretches, random stalling at a
   // varying rate, and further long hold-offs.
   initial begin
      int unsigned kind;
      int unsigned len;
      int unsigned pct;
      do @(posedge clock); while (reset);
      rsp_stall <= 1'b1;
      repeat (48) @(posedge clock);
      forever begin
         kind = $urandom_range(0, 9);
         len  = $urandom_range(10, 60);
         if (kind == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(30, 60)) @(posedge clock);
         end else if (kind < 4) begin
            rsp_stall <= 1'b0;
            repeat (len) @(posedge clock);
         end else begin
            pct = $urandom_range(10, 70);
            repeat (len) begin
               rsp_stall <= ($urandom_range(0, 99) < pct);
               @(posedge clock);
            end
         end
      end
   end

   // A word is taken at every edge where the block offers one and the
   // receiver is not stalling; the values seen here are those before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_word(rsp_counter_pwm, rsp_ring_pwm, rsp_corner_pwm,
                       rsp_mode_led, rsp_pressed_button);
      end
   end

   // A limit far beyond the slowest correct run, even with the longest gaps and
   // stalls.
   initial begin
      #2000000;
      $display("tb_top NOT OK");
      $finish;
   end

endmodule
